// File: rtl/mcv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the max-cut value evaluator.
// No dependencies.
package mcv_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 8;
  localparam int PAIR_COUNT   = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int VERT_W       = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
  localparam int SLOT_W       = $clog2(PAIR_COUNT + 1);
  localparam int ADDR_W       = $clog2(PAIR_COUNT);
  localparam int VALUE_W      = 15;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EVAL  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [VALUE_W-1:0]     value_t;

endpackage

// File: rtl/mcv_weight_mem.sv
`timescale 1ns / 1ps
// Pair weight memory: one write port, one registered read port, per-entry valid bits.
// Depends on mcv_pkg.
module mcv_weight_mem
  import mcv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  weight_t           wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output weight_t           rd_data
);

  weight_t                 mem [PAIR_COUNT];
  logic [PAIR_COUNT-1:0]   entry_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= entry_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

endmodule

// File: rtl/max_cut_value_evaluator.sv
`timescale 1ns / 1ps
// Top level of the weighted max-cut value evaluator.
// Depends on mcv_pkg and mcv_weight_mem.
//
// Input channel (in_valid / in_stall) carries one beat per item:
//   kind 0 writes edge_weight for pair (vertex_a, vertex_b); equal vertices drop.
//   kind 1 evaluates assignment and returns one output beat.
//   kind 2 clears the running best value. kind 3 drops.
// Writes and clears give no output beat.
// An evaluate walks all stored pairs, one memory read per cycle, and keeps the
// input stalled through the walk, a drain state and a finish state; the
// output beat appears at the same edge that releases the input. The walk
// length is set by the single read port of the pair weight memory.
// Output channel (out_valid / out_stall) holds cut_value, best_cut and
// out_of_range until taken. A stalled output beat holds; the next evaluate
// still runs and waits at its end until the output register frees.
// cfg_wr_en / cfg_wr_data set active_vertices; write only while idle.
// Reset (rst, synchronous) clears all weights to zero, the best value to
// zero, active_vertices to 16 and drops any pending output beat.
module max_cut_value_evaluator
  import mcv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [4:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic [VERT_W-1:0]    vertex_a,
  input  logic [VERT_W-1:0]    vertex_b,
  input  logic [7:0]           edge_weight,
  input  logic [15:0]          assignment,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VALUE_W-1:0]   cut_value,
  output logic [VALUE_W-1:0]   best_cut,
  output logic                 out_of_range
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                    state;
  logic [4:0]                active_vertices;
  logic [COUNT_W-1:0]        n_eff;
  logic [COUNT_W-1:0]        n_lat;
  logic [MAX_VERTICES-1:0]   assign_lat;
  logic                      flag_lat;
  logic [VERT_W-1:0]         vi;
  logic [VERT_W-1:0]         vj;
  logic [SLOT_W-1:0]         slot;
  logic                      s1_valid;
  logic                      s1_use;
  value_t                    sum;
  value_t                    best;
  value_t                    best_next;
  value_t                    sum_next;
  logic [VALUE_W:0]          sum_ext;
  logic                      in_accept;
  logic                      out_free;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic                      flag_now;
  weight_t                   rd_data;
  logic [VERT_W-1:0]         lo;
  logic [VERT_W-1:0]         hi;

  function automatic logic [ADDR_W-1:0] pair_slot(
    input logic [VERT_W-1:0] a_lo,
    input logic [VERT_W-1:0] a_hi
  );
    logic [2*VERT_W+1:0] prod;
    logic [2*VERT_W+1:0] s;
    prod = (2*VERT_W+2)'(a_lo) * ((2*VERT_W+2)'(2*MAX_VERTICES - 1) - (2*VERT_W+2)'(a_lo));
    s    = (prod >> 1) + (2*VERT_W+2)'(a_hi) - (2*VERT_W+2)'(a_lo) - (2*VERT_W+2)'(1);
    return s[ADDR_W-1:0];
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign n_eff = (active_vertices > 5'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                      : COUNT_W'(active_vertices);

  always_comb begin
    flag_now = 1'b0;
    for (int b = 0; b < MAX_VERTICES; b++) begin
      if (assignment[b] && (COUNT_W'(b) >= n_eff)) begin
        flag_now = 1'b1;
      end
    end
  end

  assign lo      = (vertex_a < vertex_b) ? vertex_a : vertex_b;
  assign hi      = (vertex_a < vertex_b) ? vertex_b : vertex_a;
  assign wr_en   = in_accept && (kind == KIND_WRITE) && (vertex_a != vertex_b);
  assign wr_addr = pair_slot(lo, hi);

  mcv_weight_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (weight_t'(edge_weight)),
    .rd_en   (state == ST_RUN),
    .rd_addr (slot[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign sum_ext   = {1'b0, sum} + (VALUE_W+1)'(rd_data);
  assign sum_next  = sum_ext[VALUE_W] ? '1 : sum_ext[VALUE_W-1:0];
  assign best_next = (sum > best) ? sum : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_vertices <= 5'(MAX_VERTICES);
    end else if (cfg_wr_en) begin
      active_vertices <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      best      <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
      s1_use   <= (assign_lat[vi] ^ assign_lat[vj]) && (COUNT_W'(vj) < n_lat);
      if (s1_valid && s1_use) begin
        sum <= sum_next;
      end
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            unique case (kind)
              KIND_EVAL: begin
                state      <= ST_RUN;
                n_lat      <= n_eff;
                assign_lat <= assignment;
                flag_lat   <= flag_now;
                vi         <= '0;
                vj         <= VERT_W'(1);
                slot       <= '0;
                sum        <= '0;
              end
              KIND_CLEAR: begin
                best <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          slot <= slot + SLOT_W'(1);
          if (vj == VERT_W'(MAX_VERTICES - 1)) begin
            if (vi == VERT_W'(MAX_VERTICES - 2)) begin
              state <= ST_DRAIN;
            end else begin
              vi <= vi + VERT_W'(1);
              vj <= vi + VERT_W'(2);
            end
          end else begin
            vj <= vj + VERT_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            cut_value    <= sum;
            best_cut     <= best_next;
            out_of_range <= flag_lat;
            best         <= best_next;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (slot == SLOT_W'(PAIR_COUNT)))
    else $error("pair walk ended at wrong slot count");

  a_cut_le_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cut_value <= best_cut))
    else $error("cut value above best value");

  a_idle_no_acc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !s1_valid)
    else $error("accumulation pending while idle");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !wr_en)
    else $error("weight write during pair walk");

endmodule
